### src/afeg_pkg.sv
`timescale 1ns / 1ps
// afeg_pkg: shared types, constants and the sin^2 table generator for the
// fade envelope gain block. No dependencies.
package afeg_pkg;

  localparam int unsigned SampleBits  = 16;
  localparam int unsigned RampBits    = 20;
  localparam int unsigned StepBits    = 25;
  localparam int unsigned HoldBits    = 24;
  localparam int unsigned GainBits    = 18;
  localparam int unsigned ChanBits    = 2;
  localparam int unsigned CountBits   = 21;
  localparam int unsigned PhaseBits   = 27;
  localparam int unsigned FoldBits    = 25;  // phase modulo one half turn
  localparam int unsigned GBits       = 17;  // table value with unity = 2^16
  localparam int unsigned EnvBits     = 18;  // Q4.14 envelope
  localparam int unsigned GainFrac    = 14;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 25;

  localparam longint unsigned PiQ30 = 64'd3373259426;
  localparam longint unsigned TaylorDiv [9] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
  };

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_IN   = 2'd1,
    MODE_HOLD = 2'd2,
    MODE_OUT  = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_RAMP_LENGTH = 3'd0,
    CFG_PHASE_STEP  = 3'd1,
    CFG_HOLD_LENGTH = 3'd2,
    CFG_LEVEL_GAIN  = 3'd3,
    CFG_CHAN_MODE   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic                         start_fade;
    logic signed [SampleBits-1:0] left_in;
    logic signed [SampleBits-1:0] right_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] left_out;
    logic signed [SampleBits-1:0] right_out;
    logic                         fade_in_done;
    logic                         fade_out_done;
    logic [1:0]                   envelope_phase;
  } out_item_t;

  // per-item status carried alongside the datapath
  typedef struct packed {
    logic  fade_in_done;
    logic  fade_out_done;
    mode_e phase;
  } stat_t;

  // table lookup qualifiers: flat gain, or exactly a quarter turn
  typedef struct packed {
    logic flat;
    logic full;
  } env_req_t;

  // round(65536 * sin^2(pi/2 * k / 2^tb)) via a fixed Q30 Taylor series;
  // evaluated at elaboration only
  function automatic logic [15:0] sin_sq_entry(input int unsigned k,
                                               input int unsigned tb);
    longint unsigned theta;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sq;
    longint unsigned v;
    longint          s;
    theta = (PiQ30 * longint'(k)) >> (tb + 1);
    x2    = (theta * theta) >> 30;
    term  = theta;
    s     = longint'(theta);
    for (int n = 1; n <= 9; n++) begin
      term = ((term * x2) >> 30) / TaylorDiv[n-1];
      if ((n % 2) == 1) begin
        s = s - longint'(term);
      end else begin
        s = s + longint'(term);
      end
    end
    if (s < 0) begin
      s = 0;
    end
    if (s > longint'(64'd1 << 30)) begin
      s = longint'(64'd1 << 30);
    end
    sq = longint'(s) * longint'(s);
    v  = (sq + (64'd1 << 43)) >> 44;
    if (v > 64'd65535) begin
      v = 64'd65535;
    end
    return v[15:0];
  endfunction

endpackage

### src/afeg_ctrl.sv
`timescale 1ns / 1ps
// afeg_ctrl: fade envelope sequencer (idle, fade in, hold, fade out) with
// ramp and hold counters and table index generation. Uses afeg_pkg.
module afeg_ctrl #(
  parameter int unsigned TABLE_BITS = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             fire_i,
  input  logic                             start_i,
  input  logic [afeg_pkg::RampBits-1:0]    ramp_length_i,
  input  logic [afeg_pkg::StepBits-1:0]    ramp_phase_step_i,
  input  logic [afeg_pkg::HoldBits-1:0]    hold_length_i,
  output logic [TABLE_BITS-1:0]            idx_o,
  output afeg_pkg::env_req_t               req_o,
  output afeg_pkg::stat_t                  stat_o
);
  import afeg_pkg::*;

  localparam logic [FoldBits-1:0] Quarter  = FoldBits'(1) << (FoldBits - 1);
  localparam logic [FoldBits:0]   HalfTurn = (FoldBits + 1)'(1) << FoldBits;

  mode_e                 mode_q, mode_d;
  logic [CountBits-1:0]  ramp_cnt_q, ramp_cnt_d;
  logic [PhaseBits-1:0]  phase_q, phase_d;
  logic [HoldBits-1:0]   hold_cnt_q, hold_cnt_d;

  mode_e                 mode_s, mode_h, mode_o;
  logic [CountBits-1:0]  ramp_cnt_s;
  logic [PhaseBits-1:0]  phase_s;
  logic [HoldBits-1:0]   hold_cnt_h;
  logic                  in_done, to_out, out_done, trans;
  logic [FoldBits-1:0]   p_raw, p_fold;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      ramp_cnt_q <= '0;
      phase_q    <= '0;
      hold_cnt_q <= '0;
    end else begin
      mode_q     <= mode_d;
      ramp_cnt_q <= ramp_cnt_d;
      phase_q    <= phase_d;
      hold_cnt_q <= hold_cnt_d;
    end
  end

  always_comb begin
    // a start resets the ramp before this item is scaled
    mode_s     = start_i ? MODE_IN : mode_q;
    ramp_cnt_s = start_i ? '0 : ramp_cnt_q;
    phase_s    = start_i ? '0 : phase_q;

    in_done    = (mode_s == MODE_IN) && (ramp_cnt_s == {1'b0, ramp_length_i});
    mode_h     = in_done ? MODE_HOLD : mode_s;
    hold_cnt_h = in_done ? '0 : hold_cnt_q;
    to_out     = (mode_h == MODE_HOLD) && (hold_cnt_h == hold_length_i);
    mode_o     = to_out ? MODE_OUT : mode_h;
    out_done   = (mode_o == MODE_OUT) && (ramp_cnt_s == {ramp_length_i, 1'b0});
    trans      = in_done || to_out;

    mode_d     = mode_q;
    ramp_cnt_d = ramp_cnt_q;
    phase_d    = phase_q;
    hold_cnt_d = hold_cnt_q;
    if (fire_i) begin
      mode_d     = out_done ? MODE_IDLE : mode_o;
      ramp_cnt_d = ramp_cnt_s;
      phase_d    = phase_s;
      hold_cnt_d = hold_cnt_h;
      if (!trans) begin
        case (mode_d)
          MODE_IN, MODE_OUT: begin
            ramp_cnt_d = ramp_cnt_s + CountBits'(1);
            phase_d    = phase_s + PhaseBits'(ramp_phase_step_i);
          end
          MODE_HOLD: begin
            hold_cnt_d = hold_cnt_h + HoldBits'(1);
          end
          default: begin
          end
        endcase
      end
    end

    // sin^2 is symmetric about the quarter turn
    p_raw  = phase_s[FoldBits-1:0];
    p_fold = (p_raw > Quarter) ? FoldBits'(HalfTurn - {1'b0, p_raw}) : p_raw;

    idx_o        = p_fold[FoldBits-2 -: TABLE_BITS];
    req_o.flat   = (ramp_length_i == '0);
    req_o.full   = p_fold[FoldBits-1];
    stat_o.fade_in_done  = in_done;
    stat_o.fade_out_done = out_done;
    stat_o.phase         = out_done ? MODE_IDLE : mode_o;
  end

`ifndef SYNTHESIS
  a_hold_without_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(mode_q) && $stable(ramp_cnt_q) && $stable(phase_q)
                && $stable(hold_cnt_q))
    else $error("envelope state moved without an item");

  a_out_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && stat_o.fade_out_done |=> mode_q == MODE_IDLE)
    else $error("fade-out end did not return to idle");
`endif

endmodule

### src/afeg_env.sv
`timescale 1ns / 1ps
// afeg_env: sin^2 quarter-wave ROM with registered read, then the level
// gain multiply into a registered Q4.14 envelope. Uses afeg_pkg.
module afeg_env #(
  parameter int unsigned TABLE_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [TABLE_BITS-1:0]         idx_i,
  input  afeg_pkg::env_req_t            req_i,
  input  logic [afeg_pkg::GainBits-1:0] level_gain_i,
  output logic [afeg_pkg::EnvBits-1:0]  env_o
);
  import afeg_pkg::*;

  localparam int unsigned TableSize = 1 << TABLE_BITS;
  localparam int unsigned ProdBits  = GBits + GainBits;
  localparam logic [GBits-1:0]    Unity     = GBits'(1) << (GBits - 1);
  localparam logic [ProdBits-1:0] GainRound = ProdBits'(1) << (GBits - 2);

  typedef logic [15:0] rom_t [TableSize];

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < int'(TableSize); k++) begin
      r[k] = sin_sq_entry(k, TABLE_BITS);
    end
    return r;
  endfunction

  localparam rom_t SqRom = build_rom();

  logic [15:0]         rom_q;
  env_req_t            req_q;
  logic [EnvBits-1:0]  env_q;
  logic [GBits-1:0]    g;
  logic [ProdBits-1:0] prod;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rom_q <= SqRom[idx_i];
      req_q <= req_i;
    end
  end

  always_comb begin
    g    = (req_q.flat || req_q.full) ? Unity : {1'b0, rom_q};
    prod = ProdBits'(g) * ProdBits'(level_gain_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      env_q <= EnvBits'((prod + GainRound) >> (GBits - 1));
    end
  end

  assign env_o = env_q;

endmodule

### src/afeg_lane.sv
`timescale 1ns / 1ps
// afeg_lane: one channel lane: sample times envelope into a product
// register, then rounding and saturation. Uses afeg_pkg.
module afeg_lane (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [afeg_pkg::SampleBits-1:0] sample_i,
  input  logic [afeg_pkg::EnvBits-1:0]        env_i,
  output logic signed [afeg_pkg::SampleBits-1:0] result_o
);
  import afeg_pkg::*;

  localparam int unsigned ProdBits = SampleBits + EnvBits + 1;
  localparam int unsigned QBits    = ProdBits - GainFrac;
  localparam logic signed [ProdBits-1:0] RoundC = ProdBits'(1) << (GainFrac - 1);
  localparam logic signed [QBits-1:0]    QMax   = QBits'((1 << (SampleBits - 1)) - 1);
  localparam logic signed [QBits-1:0]    QMin   = -QMax - QBits'(1);

  logic signed [ProdBits-1:0] prod_q;
  logic signed [ProdBits-1:0] rnd;
  logic signed [QBits-1:0]    q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= ProdBits'(sample_i) * ProdBits'($signed({1'b0, env_i}));
    end
  end

  always_comb begin
    rnd = prod_q + RoundC;
    q   = QBits'(rnd >>> GainFrac);  // floor division
    if (q > QMax) begin
      result_o = SampleBits'(QMax);
    end else if (q < QMin) begin
      result_o = SampleBits'(QMin);
    end else begin
      result_o = q[SampleBits-1:0];
    end
  end

endmodule

### src/audio_fade_envelope_gain.sv
`timescale 1ns / 1ps
// audio_fade_envelope_gain: top level. From item accept to result valid an item
// passes the ROM read, gain multiply, lane multiply and output register stages.
// Throughput is one item per cycle; the whole pipe stalls while a result waits.
// rst_ni (async, active low) clears the envelope sequencer, the valid bits and
// the registers to their defaults (level gain unity); the ROM is constant.
module audio_fade_envelope_gain #(
  parameter int unsigned TABLE_BITS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [afeg_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [afeg_pkg::CfgDataBits-1:0]  cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  afeg_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output afeg_pkg::out_item_t               out_item_o
);
  import afeg_pkg::*;

  logic [RampBits-1:0] ramp_len_q;
  logic [StepBits-1:0] step_q;
  logic [HoldBits-1:0] hold_len_q;
  logic [GainBits-1:0] gain_q;
  logic [ChanBits-1:0] chan_q;

  logic adv, fire;
  logic v1_q, v2_q, v3_q, out_valid_q;
  in_item_t  smp1_q, smp2_q;
  stat_t     stat, st1_q, st2_q, st3_q;
  out_item_t out_q;

  logic [TABLE_BITS-1:0]        idx;
  env_req_t                     req;
  logic [EnvBits-1:0]           env;
  logic signed [SampleBits-1:0] left_res, right_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_len_q <= '0;
      step_q     <= '0;
      hold_len_q <= '0;
      gain_q     <= GainBits'(1 << GainFrac);
      chan_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RAMP_LENGTH: ramp_len_q <= cfg_wdata_i[RampBits-1:0];
        CFG_PHASE_STEP:  step_q     <= cfg_wdata_i[StepBits-1:0];
        CFG_HOLD_LENGTH: hold_len_q <= cfg_wdata_i[HoldBits-1:0];
        CFG_LEVEL_GAIN:  gain_q     <= cfg_wdata_i[GainBits-1:0];
        CFG_CHAN_MODE:   chan_q     <= cfg_wdata_i[ChanBits-1:0];
        default: begin
        end
      endcase
    end
  end

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign fire       = in_valid_i && adv;

  afeg_ctrl #(.TABLE_BITS(TABLE_BITS)) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .fire_i            (fire),
    .start_i           (in_item_i.start_fade),
    .ramp_length_i     (ramp_len_q),
    .ramp_phase_step_i (step_q),
    .hold_length_i     (hold_len_q),
    .idx_o             (idx),
    .req_o             (req),
    .stat_o            (stat)
  );

  afeg_env #(.TABLE_BITS(TABLE_BITS)) u_env (
    .clk_i        (clk_i),
    .en_i         (adv),
    .idx_i        (idx),
    .req_i        (req),
    .level_gain_i (gain_q),
    .env_o        (env)
  );

  afeg_lane u_lane_left (
    .clk_i    (clk_i),
    .en_i     (adv),
    .sample_i (smp2_q.left_in),
    .env_i    (env),
    .result_o (left_res)
  );

  afeg_lane u_lane_right (
    .clk_i    (clk_i),
    .en_i     (adv),
    .sample_i (smp2_q.right_in),
    .env_i    (env),
    .result_o (right_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  // merge: lane results, channel mute and item status
  always_ff @(posedge clk_i) begin
    if (adv) begin
      smp1_q <= in_item_i;
      smp2_q <= smp1_q;
      st1_q  <= stat;
      st2_q  <= st1_q;
      st3_q  <= st2_q;
      out_q.left_out       <= chan_q[1] ? '0 : left_res;
      out_q.right_out      <= chan_q[0] ? '0 : right_res;
      out_q.fade_in_done   <= st3_q.fade_in_done;
      out_q.fade_out_done  <= st3_q.fade_out_done;
      out_q.envelope_phase <= st3_q.phase;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_in_done_leaves_fade_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.fade_in_done |-> out_item_o.envelope_phase != MODE_IN)
    else $error("fade-in end reported while still fading in");

  a_out_done_is_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.fade_out_done |-> out_item_o.envelope_phase == MODE_IDLE)
    else $error("fade-out end reported without idle phase");
`endif

endmodule

### tb/audio_fade_envelope_gain_tb.sv
`timescale 1ns / 1ps
// audio_fade_envelope_gain_tb: self-checking bench for the fade envelope gain block.
// Every accepted frame is predicted by an envelope model kept in this file.
// Depends on afeg_pkg and the audio_fade_envelope_gain RTL.
module audio_fade_envelope_gain_tb;
  import afeg_pkg::*;

  localparam int unsigned TableBits     = 10;
  localparam int unsigned TableSize     = 1 << TableBits;
  localparam longint unsigned PiFixed   = 64'd3373259426;  // pi in Q30
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned SettleCycles  = 8;
  localparam logic [CfgIdxBits-1:0] CfgIdxUnused = 3'd7;
  localparam logic [GBits-1:0] UnityTableGain = 17'h10000;
  localparam longint SampleMax = (longint'(1) << (SampleBits - 1)) - 1;
  localparam longint SampleMin = -SampleMax - 1;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_wdata_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  in_item_t               in_item_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  out_item_t              out_item_o;

  // envelope model state and register copies
  logic [15:0]           sq_table_rom [TableSize];
  mode_e                 env_mode;
  logic [CountBits-1:0]  ramp_cnt;
  logic [PhaseBits-1:0]  ramp_acc;
  logic [HoldBits-1:0]   hold_cnt;
  logic [RampBits-1:0]   reg_ramp_len;
  logic [StepBits-1:0]   reg_step;
  logic [HoldBits-1:0]   reg_hold_len;
  logic [GainBits-1:0]   reg_gain;
  logic [ChanBits-1:0]   reg_chan;

  out_item_t expected_frames [$];
  int        error_count  = 0;
  int        results_seen = 0;
  int        cycle_count  = 0;
  bit        tx_idle_en   = 1'b1;
  bit        rx_idle_en   = 1'b1;
  bit        hold_off_req = 1'b0;

  audio_fade_envelope_gain #(
    .TABLE_BITS(TableBits)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // sin^2 of a quarter-wave point, Q30 Taylor series rounded to 16 bits
  function automatic logic [15:0] quarter_sin_sq(input int unsigned k);
    longint unsigned theta;
    longint unsigned theta_sq;
    longint unsigned term;
    longint unsigned sq;
    longint unsigned rounded;
    longint          sine;
    theta    = (PiFixed * 64'(k)) >> (TableBits + 1);
    theta_sq = (theta * theta) >> 30;
    term     = theta;
    sine     = longint'(theta);
    for (int n = 1; n <= 9; n++) begin
      term = ((term * theta_sq) >> 30) / 64'(2 * n * (2 * n + 1));
      if (n % 2 == 1) begin
        sine = sine - longint'(term);
      end else begin
        sine = sine + longint'(term);
      end
    end
    if (sine < 0) begin
      sine = 0;
    end
    if (sine > (longint'(1) << 30)) begin
      sine = longint'(1) << 30;
    end
    sq      = 64'(sine) * 64'(sine);
    rounded = (sq + (64'd1 << 43)) >> 44;
    if (rounded > 64'd65535) begin
      rounded = 64'd65535;
    end
    return rounded[15:0];
  endfunction

  function automatic logic [SampleBits-1:0] scale_sample(input logic signed [SampleBits-1:0] x,
                                                         input logic [EnvBits-1:0] env);
    longint prod;
    longint q;
    prod = longint'(x) * longint'(env) + 64'sd8192;
    q    = prod >>> GainFrac;  // floor division
    if (q > SampleMax) begin
      q = SampleMax;
    end
    if (q < SampleMin) begin
      q = SampleMin;
    end
    return q[SampleBits-1:0];
  endfunction

  task automatic reset_model();
    for (int k = 0; k < TableSize; k++) begin
      sq_table_rom[k] = quarter_sin_sq(k);
    end
    env_mode     = MODE_IDLE;
    ramp_cnt     = '0;
    ramp_acc     = '0;
    hold_cnt     = '0;
    reg_ramp_len = '0;
    reg_step     = '0;
    reg_hold_len = '0;
    reg_gain     = GainBits'(16384);
    reg_chan     = '0;
  endtask

  // advances the envelope sequencer by one frame and returns the result
  function automatic out_item_t predict_frame(input in_item_t frame);
    out_item_t          res;
    logic [GBits-1:0]   g;
    logic [FoldBits:0]  fold;
    logic [TableBits:0] idx;
    logic [EnvBits-1:0] env;
    logic               moved;
    res   = '0;
    moved = 1'b0;
    if (frame.start_fade) begin
      ramp_cnt = '0;
      ramp_acc = '0;
      env_mode = MODE_IN;
    end
    if (reg_ramp_len == '0) begin
      g = UnityTableGain;
    end else begin
      fold = {1'b0, ramp_acc[FoldBits-1:0]};
      if (fold > (26'd1 << 24)) begin
        fold = (26'd1 << 25) - fold;  // second half of the half turn mirrors the first
      end
      idx = (TableBits + 1)'(fold >> (24 - TableBits));
      if (idx >= TableSize) begin
        g = UnityTableGain;
      end else begin
        g = {1'b0, sq_table_rom[idx[TableBits-1:0]]};
      end
    end
    env = EnvBits'((longint'(g) * longint'(reg_gain) + 64'sd32768) >>> 16);
    res.left_out  = scale_sample(frame.left_in, env);
    res.right_out = scale_sample(frame.right_in, env);
    if (reg_chan[1]) begin
      res.left_out = '0;
    end
    if (reg_chan[0]) begin
      res.right_out = '0;
    end

    if (env_mode == MODE_IN && ramp_cnt == CountBits'(reg_ramp_len)) begin
      res.fade_in_done = 1'b1;
      env_mode         = MODE_HOLD;
      hold_cnt         = '0;
      moved            = 1'b1;
    end
    if (env_mode == MODE_HOLD && hold_cnt == reg_hold_len) begin
      env_mode = MODE_OUT;
      moved    = 1'b1;
    end
    if (env_mode == MODE_OUT && ramp_cnt == {reg_ramp_len, 1'b0}) begin
      res.fade_out_done = 1'b1;
      env_mode          = MODE_IDLE;
    end
    if (!moved && (env_mode == MODE_IN || env_mode == MODE_OUT)) begin
      ramp_cnt = ramp_cnt + 1'b1;
      ramp_acc = ramp_acc + PhaseBits'(reg_step);
    end
    if (!moved && env_mode == MODE_HOLD) begin
      hold_cnt = hold_cnt + 1'b1;
    end
    res.envelope_phase = env_mode;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] frame %0d: %s", $time, results_seen, what);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] got,
                             input logic signed [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  always @(posedge clk_i) begin : frame_checker
    out_item_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (expected_frames.size() == 0) begin
        report_mismatch("result with no frame outstanding");
      end else begin
        want = expected_frames.pop_front();
        check_field("left_out", out_item_o.left_out, want.left_out);
        check_field("right_out", out_item_o.right_out, want.right_out);
        check_field("fade_in_done", out_item_o.fade_in_done, want.fade_in_done);
        check_field("fade_out_done", out_item_o.fade_out_done, want.fade_out_done);
        check_field("envelope_phase", out_item_o.envelope_phase, want.envelope_phase);
      end
      results_seen++;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic write_register(input logic [CfgIdxBits-1:0] idx,
                                input logic [CfgDataBits-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_RAMP_LENGTH: reg_ramp_len = data[RampBits-1:0];
      CFG_PHASE_STEP:  reg_step     = data[StepBits-1:0];
      CFG_HOLD_LENGTH: reg_hold_len = data[HoldBits-1:0];
      CFG_LEVEL_GAIN:  reg_gain     = data[GainBits-1:0];
      CFG_CHAN_MODE:   reg_chan     = data[ChanBits-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_frame(input logic start, input int left, input int right);
    in_item_t frame;
    frame.start_fade = start;
    frame.left_in    = left[SampleBits-1:0];
    frame.right_in   = right[SampleBits-1:0];
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= frame;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    expected_frames.insert(expected_frames.size(), predict_frame(frame));
  endtask

  // stop offering items and let the pipe empty before touching registers
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic int random_sample();
    case ($urandom_range(0, 7))
      0:       return int'(SampleMin);
      1:       return int'(SampleMax);
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // register value with junk above its width now and then
  function automatic logic [CfgDataBits-1:0] pad_word(input logic [CfgDataBits-1:0] value,
                                                      input int unsigned width);
    logic [CfgDataBits-1:0] keep;
    keep = (width >= CfgDataBits) ? '1 : ((CfgDataBits'(1) << width) - 1'b1);
    if ($urandom_range(0, 3) == 0) begin
      return (CfgDataBits'($urandom()) & ~keep) | (value & keep);
    end
    return value & keep;
  endfunction

  task automatic program_random_settings();
    logic [RampBits-1:0] len;
    logic [StepBits-1:0] step;
    logic [HoldBits-1:0] hold;
    logic [GainBits-1:0] gain;
    logic [ChanBits-1:0] chan;
    int unsigned         pick;
    pick = $urandom_range(0, 9);
    if (pick < 8) begin
      len = RampBits'($urandom_range(0, 12));
    end else if (pick == 8) begin
      len = '1;
    end else begin
      len = RampBits'($urandom());
    end
    pick = $urandom_range(0, 19);
    if (pick < 12 && len != '0) begin
      step = StepBits'((32'd16777216 + 32'(len) / 2) / 32'(len));
    end else if (pick < 17) begin
      step = StepBits'($urandom());
    end else begin
      step = StepBits'(32'd16777216);
    end
    pick = $urandom_range(0, 9);
    if (pick < 8) begin
      hold = HoldBits'($urandom_range(0, 10));
    end else if (pick == 8) begin
      hold = '1;
    end else begin
      hold = HoldBits'($urandom());
    end
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      gain = GainBits'(16384);
    end else if (pick < 8) begin
      gain = GainBits'($urandom());
    end else if (pick == 8) begin
      gain = '0;
    end else begin
      gain = '1;
    end
    chan = ($urandom_range(0, 9) < 6) ? '0 : ChanBits'($urandom_range(0, 3));
    write_register(CFG_RAMP_LENGTH, pad_word(len, RampBits));
    write_register(CFG_PHASE_STEP, pad_word(step, StepBits));
    write_register(CFG_HOLD_LENGTH, pad_word(hold, HoldBits));
    write_register(CFG_LEVEL_GAIN, pad_word(gain, GainBits));
    write_register(CFG_CHAN_MODE, pad_word(chan, ChanBits));
  endtask

  task automatic program_fade(input int unsigned len, input int unsigned hold);
    write_register(CFG_RAMP_LENGTH, CfgDataBits'(len));
    write_register(CFG_PHASE_STEP, CfgDataBits'((32'd16777216 + len / 2) / len));
    write_register(CFG_HOLD_LENGTH, CfgDataBits'(hold));
    write_register(CFG_LEVEL_GAIN, CfgDataBits'(16384));
    write_register(CFG_CHAN_MODE, '0);
  endtask

  // reset registers: flat unity gain passes samples through
  task automatic test_reset_flat();
    settle_block();
    send_frame(1'b0, int'(SampleMin), int'(SampleMax));
    send_frame(1'b0, int'(SampleMax), int'(SampleMin));
    send_frame(1'b0, -1, 1);
  endtask

  task automatic test_gain_extremes();
    settle_block();
    write_register(CFG_LEVEL_GAIN, '1);
    send_frame(1'b0, int'(SampleMax), int'(SampleMin));
    send_frame(1'b0, 100, -100);
    settle_block();
    write_register(CFG_LEVEL_GAIN, '0);
    send_frame(1'b0, int'(SampleMin), int'(SampleMax));
    settle_block();
    write_register(CFG_LEVEL_GAIN, CfgDataBits'(16384));
  endtask

  // left only, right only, and both muted
  task automatic test_channel_modes();
    for (int m = 1; m <= 3; m++) begin
      settle_block();
      write_register(CFG_CHAN_MODE, CfgDataBits'(m));
      send_frame(1'b0, 12345, -23456);
    end
    settle_block();
    write_register(CfgIdxUnused, '1);  // no such register, must be ignored
    write_register(CFG_CHAN_MODE, '0);
  endtask

  // full in / hold / out cycle including the wrap back to zero gain
  task automatic test_fade_cycle();
    settle_block();
    program_fade(2, 1);
    send_frame(1'b1, 20000, -20000);
    for (int n = 0; n < 8; n++) begin
      send_frame(1'b0, 20000, -20000);
    end
  endtask

  task automatic test_restart_mid_fade();
    settle_block();
    program_fade(3, 2);
    send_frame(1'b1, 30000, -30000);
    send_frame(1'b0, 30000, -30000);
    send_frame(1'b1, 30000, -30000);
    send_frame(1'b0, 30000, -30000);
    send_frame(1'b0, 30000, -30000);
    send_frame(1'b0, 30000, -30000);
  endtask

  // long receiver hold-off while the sender keeps offering frames
  task automatic test_output_backpressure();
    bit saved_idle;
    settle_block();
    program_fade(4, 3);
    saved_idle   = tx_idle_en;
    tx_idle_en   = 1'b0;
    hold_off_req = 1'b1;
    send_frame(1'b1, random_sample(), random_sample());
    for (int n = 0; n < 59; n++) begin
      send_frame(1'b0, random_sample(), random_sample());
    end
    tx_idle_en = saved_idle;
  endtask

  // mostly well-formed fades with random content; the envelope carries over
  // between phases, so register changes also land mid-fade
  task automatic test_random_envelopes(input int unsigned phases, input int unsigned frames,
                                       input bit with_extremes);
    logic start;
    for (int unsigned ph = 0; ph < phases; ph++) begin
      settle_block();
      if (with_extremes && ph == 0) begin
        write_register(CFG_RAMP_LENGTH, '1);
        write_register(CFG_PHASE_STEP, '1);
        write_register(CFG_HOLD_LENGTH, '1);
        write_register(CFG_LEVEL_GAIN, '1);
        write_register(CFG_CHAN_MODE, CfgDataBits'(2));
      end else if (with_extremes && ph == 1) begin
        write_register(CFG_RAMP_LENGTH, '0);
        write_register(CFG_PHASE_STEP, '0);
        write_register(CFG_HOLD_LENGTH, '0);
        write_register(CFG_LEVEL_GAIN, '0);
        write_register(CFG_CHAN_MODE, '0);
      end else begin
        program_random_settings();
      end
      for (int unsigned n = 0; n < frames; n++) begin
        if (n == 0) begin
          start = ($urandom_range(0, 7) != 0);
        end else begin
          start = ($urandom_range(0, 49) == 0);
        end
        send_frame(start, random_sample(), random_sample());
      end
    end
  endtask

  initial begin : stimulus
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    reset_model();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_flat();
    test_gain_extremes();
    test_channel_modes();
    test_fade_cycle();
    test_restart_mid_fade();
    test_output_backpressure();
    test_random_envelopes(6, 40, 1'b1);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_envelopes(2, 40, 1'b0);
    settle_block();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
src/afeg_pkg.sv
src/afeg_ctrl.sv
src/afeg_env.sv
src/afeg_lane.sv
src/audio_fade_envelope_gain.sv
tb/audio_fade_envelope_gain_tb.sv
